// ===== hw/rtl/logistic_regression_trainer_macros.svh =====
// Assertion macros for the logistic regression trainer.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef LOGISTIC_REGRESSION_TRAINER_MACROS_SVH
`define LOGISTIC_REGRESSION_TRAINER_MACROS_SVH
`ifndef SYNTHESIS
`define LRT_ASSERT_IMP(name, clk_s, rst_n, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("lrt assertion failed");
`define LRT_ASSERT_NXT(name, clk_s, rst_n, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("lrt assertion failed");
`else
`define LRT_ASSERT_IMP(name, clk_s, rst_n, ante, cons)
`define LRT_ASSERT_NXT(name, clk_s, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/lrt_pkg.sv =====
// Types, codes, saturation helpers and the sigmoid table of the trainer.
// Depends on nothing.
package lrt_pkg;

	localparam int SIG_SIZE = 1024;
	localparam int SIG_MID = 512;
	localparam logic [63:0] EXP_STEP = 64'd4228380000;
	localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
	localparam logic signed [63:0] MIN48 = -64'sd140737488355328;
	localparam logic signed [63:0] MAX32 = 64'sd2147483647;
	localparam logic signed [63:0] MIN32 = -64'sd2147483648;

	localparam logic [1:0] KIND_PROB = 2'd0;
	localparam logic [1:0] KIND_WEIGHT = 2'd1;
	localparam logic [1:0] KIND_BIAS = 2'd2;

	localparam logic [1:0] CFG_LR = 2'd0;
	localparam logic [1:0] CFG_LAMBDA = 2'd1;
	localparam logic [1:0] CFG_INV = 2'd2;
	localparam logic [1:0] CFG_TRAIN = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEAT,
		ST_ZSUM,
		ST_ZIDX,
		ST_PROB,
		ST_EMITP,
		ST_GWALK,
		ST_UREAD,
		ST_U1,
		ST_U2,
		ST_U3,
		ST_U4,
		ST_UEMIT
	} lrt_state_t;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [47:0] acc;
		logic signed [31:0] x;
	} lrt_entry_t;

	typedef logic [16:0] sig_tab_t [SIG_SIZE];

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > MAX48) begin
			return MAX48[47:0];
		end
		if (v < MIN48) begin
			return MIN48[47:0];
		end
		return v[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > MAX32) begin
			return MAX32[31:0];
		end
		if (v < MIN32) begin
			return MIN32[31:0];
		end
		return v[31:0];
	endfunction

	// Entry k holds sigmoid((k - 512) / 64); the quotient is found by long division.
	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		logic [63:0] s;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		tab = '{default: '0};
		s = 64'd4294967296;
		for (int t = 0; t <= SIG_MID; t++) begin
			d = 64'd4294967296 + s;
			num = 64'd281474976710656 + (d >> 1);
			rem = '0;
			q = '0;
			for (int b = 48; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= d) begin
					rem = rem - d;
					q[b] = 1'b1;
				end
			end
			if (t < SIG_MID) begin
				tab[SIG_MID + t] = q[16:0];
			end
			tab[SIG_MID - t] = 17'(64'd65536 - q);
			s = (s * EXP_STEP + 64'd2147483648) >> 32;
		end
		return tab;
	endfunction

endpackage

// ===== hw/rtl/logistic_regression_trainer.sv =====
// Logistic regression trainer: a feature is read, multiplied and written back. A sample's
// last feature adds the z sum, index, probability and emit states plus, in training, a
// gradient walk over the entry memory; a batch end then updates each weight and the bias.
// The entry memory has a single read port and a single write port. Reset (arst_n low)
// clears control, accumulators and valid bits and presets the config; no clearing pass.
// Result beats wait in an output register; the block stalls while it is full.
`include "logistic_regression_trainer_macros.svh"

module logistic_regression_trainer
	import lrt_pkg::*;
#(
	parameter int NUM_FEATURES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               feature_valid,
	output logic               feature_ready,
	input  logic signed [31:0] feature_value,
	input  logic               label,
	input  logic               last_sample,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         result_kind,
	output logic signed [31:0] result_value,
	output logic [3:0]         weight_index,
	output logic               last,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [24:0]        cfg_data
);

	localparam int IW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int CW = $clog2(NUM_FEATURES + 1);
	localparam logic [IW-1:0] LAST_POS = IW'(NUM_FEATURES - 1);
	localparam logic [CW-1:0] CNT_END = CW'(NUM_FEATURES);
	localparam sig_tab_t SIG_TABLE = build_sig_table();

	lrt_state_t state_q, state_next;

	logic [24:0] lr_q;
	logic [16:0] lam_q;
	logic [16:0] inv_q;
	logic        train_q;

	lrt_entry_t mem_q [NUM_FEATURES];
	logic [NUM_FEATURES-1:0] vld_q;
	lrt_entry_t rd_q;
	logic       rd_vld_q;
	logic [IW-1:0] rd_addr;
	logic       wr_en;
	logic [IW-1:0] wr_addr;
	lrt_entry_t wr_data;

	logic signed [31:0] rd_w;
	logic signed [47:0] rd_acc;

	logic [IW-1:0]      pos_q;
	logic signed [31:0] x_q;
	logic               label_q;
	logic               lsamp_q;
	logic signed [63:0] prod_q;
	logic               pend_q;
	logic signed [47:0] dot_q;
	logic signed [47:0] dot_next;
	logic signed [31:0] bias_q;
	logic signed [47:0] bacc_q;
	logic [9:0]         zidx_q;
	logic [16:0]        p_q;
	logic signed [17:0] err;
	logic signed [17:0] err_q;
	logic               batch_end;

	logic [CW-1:0]      rd_cnt_q;
	logic               rd_issue;
	logic               v_s1;
	logic [IW-1:0]      idx_s1;
	logic               v_s2;
	logic [IW-1:0]      idx_s2;
	logic signed [49:0] gp_s2;
	lrt_entry_t         ent_s2;
	logic               gwalk_done;

	logic [CW-1:0]      upd_idx_q;
	logic               upd_bias;
	logic [16:0]        inv_eff;
	logic signed [65:0] m1_s1;
	logic signed [50:0] m2_s1;
	logic signed [31:0] uw_q;
	logic signed [31:0] ux_q;
	logic signed [47:0] g_s2;
	logic signed [57:0] ph_s3;
	logic [40:0]        pl_s3;
	logic signed [31:0] wn_q;
	logic signed [63:0] step;

	logic signed [47:0] zs;
	logic signed [47:0] zoff;
	logic [9:0]         zidx;

	logic        out_free;
	logic        emit;
	logic [1:0]  emit_kind;
	logic signed [31:0] emit_value;
	logic [3:0]  emit_idx;
	logic        emit_last;

	logic        result_valid_q;
	logic [1:0]  result_kind_q;
	logic signed [31:0] result_value_q;
	logic [3:0]  weight_index_q;
	logic        last_q;

	assign rd_w = rd_vld_q ? rd_q.w : '0;
	assign rd_acc = rd_vld_q ? rd_q.acc : '0;
	assign dot_next = sat48(64'(dot_q) + (prod_q >>> 16));
	assign err = $signed({1'b0, p_q}) - (label_q ? 18'sd65536 : 18'sd0);
	assign batch_end = train_q & lsamp_q;
	assign out_free = !result_valid_q || result_ready;
	assign rd_issue = (state_q == ST_GWALK) && (rd_cnt_q < CNT_END);
	assign gwalk_done = v_s2 && (idx_s2 == LAST_POS);
	assign upd_bias = (upd_idx_q == CNT_END);
	assign inv_eff = (inv_q > 17'd65536) ? 17'd65536 : inv_q;
	assign step = 64'(ph_s3) + $signed({39'b0, pl_s3[40:16]});

	always_comb begin
		zs = sat48(64'(dot_q) + 64'(bias_q));
		zoff = zs + 48'sd524288;
		if (zs < -48'sd524288) begin
			zidx = '0;
		end else if (zs >= 48'sd524288) begin
			zidx = '1;
		end else begin
			zidx = zoff[19:10];
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (feature_valid) begin
					state_next = ST_FEAT;
				end
			end
			ST_FEAT: begin
				state_next = (pos_q == LAST_POS) ? ST_ZSUM : ST_IDLE;
			end
			ST_ZSUM: state_next = ST_ZIDX;
			ST_ZIDX: state_next = ST_PROB;
			ST_PROB: state_next = ST_EMITP;
			ST_EMITP: begin
				if (out_free) begin
					state_next = train_q ? ST_GWALK : ST_IDLE;
				end
			end
			ST_GWALK: begin
				if (gwalk_done) begin
					state_next = batch_end ? ST_UREAD : ST_IDLE;
				end
			end
			ST_UREAD: state_next = ST_U1;
			ST_U1: state_next = ST_U2;
			ST_U2: state_next = ST_U3;
			ST_U3: state_next = ST_U4;
			ST_U4: state_next = ST_UEMIT;
			ST_UEMIT: begin
				if (out_free) begin
					state_next = upd_bias ? ST_IDLE : ST_UREAD;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		feature_ready = 1'b0;
		rd_addr = pos_q;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = '{w: rd_w, acc: rd_acc, x: x_q};
		emit = 1'b0;
		emit_kind = KIND_PROB;
		emit_value = 32'($signed({1'b0, p_q}));
		emit_idx = '0;
		emit_last = !batch_end;
		case (state_q)
			ST_IDLE: begin
				feature_ready = 1'b1;
			end
			ST_FEAT: begin
				wr_en = 1'b1;
			end
			ST_EMITP: begin
				emit = out_free;
			end
			ST_GWALK: begin
				rd_addr = rd_cnt_q[IW-1:0];
				wr_en = v_s2;
				wr_addr = idx_s2;
				wr_data = '{w: ent_s2.w,
					acc: sat48(64'(ent_s2.acc) + 64'(gp_s2 >>> 16)),
					x: ent_s2.x};
			end
			ST_UREAD: begin
				rd_addr = upd_idx_q[IW-1:0];
			end
			ST_UEMIT: begin
				emit = out_free;
				emit_value = wn_q;
				emit_kind = upd_bias ? KIND_BIAS : KIND_WEIGHT;
				emit_idx = upd_bias ? 4'd0 : 4'(upd_idx_q);
				emit_last = upd_bias;
				wr_en = out_free && !upd_bias;
				wr_addr = upd_idx_q[IW-1:0];
				wr_data = '{w: wn_q, acc: '0, x: ux_q};
			end
			default: begin
				feature_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 25'd65536;
			lam_q <= '0;
			inv_q <= 17'd65536;
			train_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LR: lr_q <= cfg_data;
				CFG_LAMBDA: lam_q <= cfg_data[16:0];
				CFG_INV: inv_q <= cfg_data[16:0];
				CFG_TRAIN: train_q <= cfg_data[0];
				default: lr_q <= lr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			pend_q <= 1'b0;
			dot_q <= '0;
			bias_q <= '0;
			bacc_q <= '0;
			rd_cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			upd_idx_q <= '0;
		end else begin
			state_q <= state_next;
			v_s1 <= rd_issue;
			v_s2 <= v_s1;
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pend_q) begin
						dot_q <= dot_next;
						pend_q <= 1'b0;
					end
				end
				ST_FEAT: begin
					if (pos_q == LAST_POS) begin
						pos_q <= '0;
					end else begin
						pos_q <= pos_q + 1'b1;
						pend_q <= 1'b1;
					end
				end
				ST_ZSUM: begin
					dot_q <= dot_next;
				end
				ST_EMITP: begin
					if (out_free) begin
						dot_q <= '0;
						rd_cnt_q <= '0;
						upd_idx_q <= '0;
						if (train_q) begin
							bacc_q <= sat48(64'(bacc_q) + 64'(err));
						end
					end
				end
				ST_UEMIT: begin
					if (out_free) begin
						if (upd_bias) begin
							bias_q <= wn_q;
							bacc_q <= '0;
						end else begin
							upd_idx_q <= upd_idx_q + 1'b1;
						end
					end
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (feature_valid && feature_ready) begin
			x_q <= feature_value;
			label_q <= label;
			lsamp_q <= last_sample;
		end
		if (state_q == ST_FEAT) begin
			prod_q <= rd_w * x_q;
		end
		if (state_q == ST_ZIDX) begin
			zidx_q <= zidx;
		end
		if (state_q == ST_PROB) begin
			p_q <= SIG_TABLE[zidx_q];
		end
		if (state_q == ST_EMITP) begin
			err_q <= err;
		end
		idx_s1 <= rd_cnt_q[IW-1:0];
		idx_s2 <= idx_s1;
		gp_s2 <= err_q * rd_q.x;
		ent_s2 <= '{w: rd_w, acc: rd_acc, x: rd_q.x};
		if (state_q == ST_U1) begin
			if (upd_bias) begin
				m1_s1 <= bacc_q * $signed({1'b0, inv_eff});
				m2_s1 <= '0;
				uw_q <= bias_q;
			end else begin
				m1_s1 <= rd_acc * $signed({1'b0, inv_eff});
				m2_s1 <= rd_w * $signed({1'b0, lam_q, 1'b0});
				uw_q <= rd_w;
			end
			ux_q <= rd_q.x;
		end
		if (state_q == ST_U2) begin
			g_s2 <= sat48(64'(m1_s1 >>> 16) + 64'(m2_s1 >>> 16));
		end
		if (state_q == ST_U3) begin
			ph_s3 <= $signed({1'b0, lr_q}) * $signed(g_s2[47:16]);
			pl_s3 <= lr_q * g_s2[15:0];
		end
		if (state_q == ST_U4) begin
			wn_q <= sat32(64'(uw_q) - step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind_q <= emit_kind;
			result_value_q <= emit_value;
			weight_index_q <= emit_idx;
			last_q <= emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result_kind = result_kind_q;
	assign result_value = result_value_q;
	assign weight_index = weight_index_q;
	assign last = last_q;

	`LRT_ASSERT_IMP(a_walk_no_overlap, clk, arst_n, rd_issue && v_s2, idx_s2 != rd_addr)
	`LRT_ASSERT_NXT(a_accept_to_feat, clk, arst_n, feature_valid && feature_ready, state_q == ST_FEAT)
	`LRT_ASSERT_IMP(a_prob_range, clk, arst_n, state_q == ST_EMITP, p_q <= 17'd65536)

endmodule
